// ===== hw/rtl/c8i_pkg.sv =====
// Shared types, opcode codes and constants of the CHIP-8 core.
package c8i_pkg;

    // Memory and display geometry
    localparam int          C_MEM_AW        = 12;
    localparam logic [11:0] C_PROGRAM_START = 12'h200;
    localparam logic [11:0] C_FONT_START    = 12'h050;
    localparam logic [11:0] C_FONT_LEN      = 12'd80;
    localparam int          C_SCREEN_WIDTH  = 64;
    localparam logic [63:0] C_COL_MASK      = ~(64'hFFFF_FFFF_FFFF_FFFF >> C_SCREEN_WIDTH);

    // Hex digit glyphs, five bytes each
    localparam logic [7:0] C_FONT [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Host commands
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EXEC  = 2'd2,
        CMD_ROW   = 2'd3
    } t_command;

    // Opcode groups (top nibble)
    localparam logic [3:0] OPG_SYS  = 4'h0;
    localparam logic [3:0] OPG_JP   = 4'h1;
    localparam logic [3:0] OPG_CALL = 4'h2;
    localparam logic [3:0] OPG_SEI  = 4'h3;
    localparam logic [3:0] OPG_SNEI = 4'h4;
    localparam logic [3:0] OPG_SER  = 4'h5;
    localparam logic [3:0] OPG_LDI  = 4'h6;
    localparam logic [3:0] OPG_ADDI = 4'h7;
    localparam logic [3:0] OPG_ALU  = 4'h8;
    localparam logic [3:0] OPG_SNER = 4'h9;
    localparam logic [3:0] OPG_LDIX = 4'hA;
    localparam logic [3:0] OPG_JPV0 = 4'hB;
    localparam logic [3:0] OPG_RND  = 4'hC;
    localparam logic [3:0] OPG_DRW  = 4'hD;
    localparam logic [3:0] OPG_KEY  = 4'hE;
    localparam logic [3:0] OPG_MISC = 4'hF;

    // Low byte selectors
    localparam logic [7:0] KK_CLS    = 8'hE0;
    localparam logic [7:0] KK_RET    = 8'hEE;
    localparam logic [7:0] KK_SKP    = 8'h9E;
    localparam logic [7:0] KK_SKNP   = 8'hA1;
    localparam logic [7:0] KK_LDDT   = 8'h07;
    localparam logic [7:0] KK_WAITK  = 8'h0A;
    localparam logic [7:0] KK_SETDT  = 8'h15;
    localparam logic [7:0] KK_ADDIX  = 8'h1E;
    localparam logic [7:0] KK_FONT   = 8'h29;
    localparam logic [7:0] KK_BCD    = 8'h33;
    localparam logic [7:0] KK_STORE  = 8'h55;
    localparam logic [7:0] KK_LOAD   = 8'h65;

    // ALU selectors (low nibble of 8xyN)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [3:0] REG_VF = 4'hF;

    // Words on the two channels
    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [15:0] keys_pressed;
    } t_in_word;

    typedef struct packed {
        logic [63:0] read_data;
        logic [11:0] program_counter;
        logic        waiting_for_key;
        logic        unimplemented;
    } t_out_word;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        U_NONE,
        U_CLEAR,
        U_ACCEPT,
        U_MEM_CAP,
        U_ROW_CAP,
        U_FETCH_HI,
        U_FETCH_LO,
        U_VX_CAP,
        U_VY_CAP,
        U_EXEC,
        U_ALU_VF,
        U_WRX,
        U_DRW_MOD,
        U_DRW_RD,
        U_DRW_XOR,
        U_DRW_VF,
        U_BCD,
        U_STR_RD,
        U_STR_WR,
        U_LD_RD,
        U_LD_WR
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_command in_cmd;
        logic [15:0] op;
        logic clr_last;
        logic cnt_eq_n;
        logic cnt_eq_x;
        logic bcd_last;
        logic sy_out;
        logic keys_none;
    } t_status;

endpackage

// ===== hw/rtl/c8i_ram.sv =====
// Generic single-port-write, registered-read RAM.
module c8i_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/c8i_ctrl.sv =====
// Sequencer of the CHIP-8 core: steps the datapath through each command.
module c8i_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  c8i_pkg::t_status i_status,
    output c8i_pkg::t_cmd   o_cmd
);
    import c8i_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MEM_CAP, S_ROW_CAP, S_FETCH_HI, S_FETCH_LO,
        S_READ_VX, S_READ_VY, S_EXEC, S_ALU_VF, S_WRX, S_DRW_MOD, S_DRW_RD,
        S_DRW_XOR, S_DRW_VF, S_BCD, S_STR_RD, S_STR_WR, S_LD_RD, S_LD_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_fire;
    logic   alu_flag, alu_plain;
    logic [3:0] grp, alu;
    logic [7:0] kk;

    assign grp = i_status.op[15:12];
    assign kk  = i_status.op[7:0];
    assign alu = i_status.op[3:0];
    assign alu_flag  = (alu == ALU_ADD) || (alu == ALU_SUB) || (alu == ALU_SHR) ||
                       (alu == ALU_SUBN) || (alu == ALU_SHL);
    assign alu_plain = (alu == ALU_MOV) || (alu == ALU_OR) || (alu == ALU_AND) ||
                       (alu == ALU_XOR);

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next state and datapath command
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd.uop    = U_NONE;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.uop = U_CLEAR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.uop = U_ACCEPT;
                    case (i_status.in_cmd)
                        CMD_WRITE: n_state = S_DONE;
                        CMD_READ:  n_state = S_MEM_CAP;
                        CMD_EXEC:  n_state = S_FETCH_HI;
                        CMD_ROW:   n_state = S_ROW_CAP;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_MEM_CAP: begin
                o_cmd.uop = U_MEM_CAP;
                n_state   = S_DONE;
            end
            S_ROW_CAP: begin
                o_cmd.uop = U_ROW_CAP;
                n_state   = S_DONE;
            end
            S_FETCH_HI: begin
                o_cmd.uop = U_FETCH_HI;
                n_state   = S_FETCH_LO;
            end
            S_FETCH_LO: begin
                o_cmd.uop = U_FETCH_LO;
                n_state   = S_READ_VX;
            end
            S_READ_VX: begin
                o_cmd.uop = U_VX_CAP;
                n_state   = S_READ_VY;
            end
            S_READ_VY: begin
                o_cmd.uop = U_VY_CAP;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.uop = U_EXEC;
                n_state   = S_DONE;
                case (grp)
                    OPG_LDI, OPG_ADDI: n_state = S_WRX;
                    OPG_ALU: begin
                        if (alu_flag) begin
                            n_state = S_ALU_VF;
                        end else if (alu_plain) begin
                            n_state = S_WRX;
                        end
                    end
                    OPG_DRW: n_state = S_DRW_MOD;
                    OPG_MISC: begin
                        case (kk)
                            KK_LDDT:  n_state = S_WRX;
                            KK_WAITK: n_state = i_status.keys_none ? S_DONE : S_WRX;
                            KK_BCD:   n_state = S_BCD;
                            KK_STORE: n_state = S_STR_RD;
                            KK_LOAD:  n_state = S_LD_RD;
                            default:  n_state = S_DONE;
                        endcase
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_ALU_VF: begin
                o_cmd.uop = U_ALU_VF;
                n_state   = S_WRX;
            end
            S_WRX: begin
                o_cmd.uop = U_WRX;
                n_state   = S_DONE;
            end
            S_DRW_MOD: begin
                o_cmd.uop = U_DRW_MOD;
                n_state   = S_DRW_RD;
            end
            S_DRW_RD: begin
                // stop at the sprite height or the bottom edge
                if (i_status.cnt_eq_n || i_status.sy_out) begin
                    n_state = S_DRW_VF;
                end else begin
                    o_cmd.uop = U_DRW_RD;
                    n_state   = S_DRW_XOR;
                end
            end
            S_DRW_XOR: begin
                o_cmd.uop = U_DRW_XOR;
                n_state   = S_DRW_RD;
            end
            S_DRW_VF: begin
                o_cmd.uop = U_DRW_VF;
                n_state   = S_DONE;
            end
            S_BCD: begin
                o_cmd.uop = U_BCD;
                if (i_status.bcd_last) begin
                    n_state = S_DONE;
                end
            end
            S_STR_RD: begin
                o_cmd.uop = U_STR_RD;
                n_state   = S_STR_WR;
            end
            S_STR_WR: begin
                o_cmd.uop = U_STR_WR;
                n_state   = i_status.cnt_eq_x ? S_DONE : S_STR_RD;
            end
            S_LD_RD: begin
                o_cmd.uop = U_LD_RD;
                n_state   = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.uop = U_LD_WR;
                n_state   = i_status.cnt_eq_x ? S_DONE : S_LD_RD;
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A memory write finishes in the cycle after acceptance
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_status.in_cmd == CMD_WRITE) |=> (r_state == S_DONE))
        else $error("write command did not finish at once");

    // Execute passes fetch high, fetch low, Vx read and Vy read before execution
    a_exec_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_status.in_cmd == CMD_EXEC) |=> ##4 (r_state == S_EXEC))
        else $error("execute did not reach the execute step in time");

    // The clearing pass runs once after reset only
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("clearing pass re-entered");

    // No input is taken while a result is still being produced
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !o_in_ready)
        else $error("input taken while a result is pending");
endmodule

// ===== hw/rtl/c8i_dp.sv =====
// Datapath of the CHIP-8 core: memories, registers, ALU, sprite and BCD logic.
module c8i_dp #(
    parameter int SCREEN_HEIGHT = 32,
    parameter int STACK_DEPTH   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  c8i_pkg::t_cmd     i_cmd,
    input  c8i_pkg::t_in_word i_in,
    output c8i_pkg::t_status  o_status,
    output c8i_pkg::t_out_word o_out
);
    import c8i_pkg::*;

    localparam int RW    = $clog2(SCREEN_HEIGHT);
    localparam int SYW   = $clog2(SCREEN_HEIGHT + 15);
    localparam int SPW   = $clog2(STACK_DEPTH);
    localparam int unsigned RECIP = 65536 / SCREEN_HEIGHT + 1;
    localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);

    // Architectural state
    logic [11:0]  r_pc;
    logic [15:0]  r_i;
    logic [SPW-1:0] r_sp;
    logic [11:0]  r_stack [STACK_DEPTH];
    logic [7:0]   r_dt;
    logic [15:0]  r_v_valid;
    logic [SCREEN_HEIGHT-1:0] r_f_valid;
    logic [11:0]  r_clr_addr;

    // Per-command working registers
    logic [15:0]  r_op;
    logic [7:0]   r_vx, r_vy;
    logic [15:0]  r_keys;
    logic [3:0]   r_cnt;
    logic [5:0]   r_px;
    logic [5:0]   r_q;
    logic [RW-1:0] r_py;
    logic         r_vf_acc;
    logic         r_row_ok;
    logic         r_v_rd_ok, r_f_rd_ok;
    logic [63:0]  r_rd;
    logic         r_wait, r_unimpl;
    t_out_word    r_out;

    // Memory ports
    logic         m_we;
    logic [11:0]  m_waddr, m_raddr;
    logic [7:0]   m_wdata, m_rdata;
    logic         v_we;
    logic [3:0]   v_waddr, v_raddr;
    logic [7:0]   v_wdata, v_rdata, vrd;
    logic         f_we;
    logic [RW-1:0] f_waddr, f_raddr;
    logic [63:0]  f_wdata, f_rdata, frow;

    // Decode and helpers
    logic [3:0]   grp, op_x, alu, n4;
    logic [7:0]   kk;
    logic [11:0]  nnn, i_cnt;
    logic [SPW-1:0] sp_inc, sp_dec;
    logic [SYW-1:0] sy;
    logic         held, skip;
    logic [8:0]   sum;
    logic [7:0]   wrx_val;
    logic         alu_vf;
    logic [3:0]   key_idx;
    logic [1:0]   bcd_h;
    logic [6:0]   bcd_rem;
    logic [3:0]   bcd_t, bcd_o;
    logic [7:0]   bcd_digit;
    logic [63:0]  spr_mask;
    logic         in_font;
    logic [6:0]   font_idx;
    logic [24:0]  py_prod;
    logic [13:0]  py_rem;

    assign grp  = r_op[15:12];
    assign op_x = r_op[11:8];
    assign alu  = r_op[3:0];
    assign n4   = r_op[3:0];
    assign kk   = r_op[7:0];
    assign nnn  = r_op[11:0];
    assign i_cnt = r_i[11:0] + 12'(r_cnt);

    assign sp_inc = (r_sp == SP_LAST) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SP_LAST : r_sp - 1'b1;
    assign sy     = SYW'(r_py) + SYW'(r_cnt);

    assign vrd  = r_v_rd_ok ? v_rdata : 8'd0;
    assign frow = r_f_rd_ok ? f_rdata : 64'd0;

    // Memories
    c8i_ram #(.WIDTH(8), .DEPTH(4096)) u_main (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );
    c8i_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );
    c8i_ram #(.WIDTH(64), .DEPTH(SCREEN_HEIGHT)) u_fb (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    // Lowest held key
    always_comb begin
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_idx = 4'(k);
            end
        end
    end

    // BCD digits by compare and subtract
    always_comb begin
        bcd_h = (r_vx >= 8'd200) ? 2'd2 : (r_vx >= 8'd100) ? 2'd1 : 2'd0;
        bcd_rem = 7'(r_vx - ({6'd0, bcd_h} * 8'd100));
        bcd_t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (bcd_rem >= 7'(k * 10)) begin
                bcd_t = 4'(k);
            end
        end
        bcd_o = 4'(bcd_rem - {bcd_t, 3'd0} - {2'd0, bcd_t, 1'b0});
        case (r_cnt[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = {4'd0, bcd_o};
        endcase
    end

    // Register write value and ALU flag
    always_comb begin
        sum     = {1'b0, r_vx} + {1'b0, r_vy};
        wrx_val = 8'd0;
        alu_vf  = 1'b0;
        case (grp)
            OPG_LDI:  wrx_val = kk;
            OPG_ADDI: wrx_val = r_vx + kk;
            OPG_ALU: begin
                case (alu)
                    ALU_MOV:  wrx_val = r_vy;
                    ALU_OR:   wrx_val = r_vx | r_vy;
                    ALU_AND:  wrx_val = r_vx & r_vy;
                    ALU_XOR:  wrx_val = r_vx ^ r_vy;
                    ALU_ADD: begin
                        wrx_val = sum[7:0];
                        alu_vf  = sum[8];
                    end
                    ALU_SUB: begin
                        wrx_val = r_vx - r_vy;
                        alu_vf  = r_vx > r_vy;
                    end
                    ALU_SHR: begin
                        wrx_val = {1'b0, r_vx[7:1]};
                        alu_vf  = r_vx[0];
                    end
                    ALU_SUBN: begin
                        wrx_val = r_vy - r_vx;
                        alu_vf  = r_vy > r_vx;
                    end
                    ALU_SHL: begin
                        wrx_val = {r_vx[6:0], 1'b0};
                        alu_vf  = r_vx[7];
                    end
                    default: wrx_val = r_vx;
                endcase
            end
            OPG_MISC: wrx_val = (kk == KK_LDDT) ? r_dt : {4'd0, key_idx};
            default:  wrx_val = r_vx;
        endcase
    end

    // Skip test for conditional groups
    always_comb begin
        held = r_keys[r_vx[3:0]];
        case (grp)
            OPG_SEI:  skip = (r_vx == kk);
            OPG_SNEI: skip = (r_vx != kk);
            OPG_SER:  skip = (r_vx == r_vy);
            OPG_SNER: skip = (r_vx != r_vy);
            OPG_KEY:  skip = ((kk == KK_SKP) && held) || ((kk == KK_SKNP) && !held);
            default:  skip = 1'b0;
        endcase
    end

    // Sprite byte placed at its column, clipped at the right edge
    assign spr_mask = ({m_rdata, 56'd0} >> r_px) & C_COL_MASK;

    // Font image for the clearing pass
    assign in_font  = (r_clr_addr >= C_FONT_START) &&
                      (r_clr_addr < C_FONT_START + C_FONT_LEN);
    assign font_idx = 7'(r_clr_addr - C_FONT_START);

    // Row start: quotient by reciprocal, then remainder
    assign py_prod = 25'(r_vy) * 25'(RECIP);
    assign py_rem  = 14'(r_vy) - 14'(r_q) * 14'(SCREEN_HEIGHT);

    // Memory port steering
    always_comb begin
        m_we = 1'b0; m_waddr = i_cnt; m_wdata = 8'd0; m_raddr = i_cnt;
        v_we = 1'b0; v_waddr = op_x;  v_wdata = wrx_val; v_raddr = op_x;
        f_we = 1'b0; f_waddr = sy[RW-1:0]; f_wdata = frow ^ spr_mask;
        f_raddr = sy[RW-1:0];
        case (i_cmd.uop)
            U_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr_addr;
                m_wdata = in_font ? C_FONT[font_idx] : 8'd0;
            end
            U_ACCEPT: begin
                m_we    = (t_command'(i_in.command) == CMD_WRITE);
                m_waddr = i_in.address;
                m_wdata = i_in.write_data;
                m_raddr = (t_command'(i_in.command) == CMD_EXEC) ? r_pc : i_in.address;
                f_raddr = i_in.address[RW-1:0];
            end
            U_FETCH_HI: m_raddr = r_pc + 12'd1;
            U_FETCH_LO: v_raddr = op_x;
            U_VX_CAP:   v_raddr = r_op[7:4];
            U_ALU_VF: begin
                v_we = 1'b1; v_waddr = REG_VF; v_wdata = {7'd0, alu_vf};
            end
            U_WRX: v_we = 1'b1;
            U_DRW_XOR: f_we = 1'b1;
            U_DRW_VF: begin
                v_we = 1'b1; v_waddr = REG_VF; v_wdata = {7'd0, r_vf_acc};
            end
            U_BCD: begin
                m_we = 1'b1; m_wdata = bcd_digit;
            end
            U_STR_RD: v_raddr = r_cnt;
            U_STR_WR: begin
                m_we = 1'b1; m_wdata = vrd;
            end
            U_LD_WR: begin
                v_we = 1'b1; v_waddr = r_cnt; v_wdata = m_rdata;
            end
            default: ;
        endcase
    end

    // Architectural state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= C_PROGRAM_START;
            r_i        <= 16'd0;
            r_sp       <= '0;
            r_dt       <= 8'd0;
            r_v_valid  <= 16'd0;
            r_f_valid  <= '0;
            r_clr_addr <= 12'd0;
            for (int k = 0; k < STACK_DEPTH; k++) begin
                r_stack[k] <= 12'd0;
            end
        end else begin
            if (i_cmd.uop == U_CLEAR) begin
                r_clr_addr <= r_clr_addr + 12'd1;
            end
            if (v_we) begin
                r_v_valid[v_waddr] <= 1'b1;
            end
            if (f_we) begin
                r_f_valid[f_waddr] <= 1'b1;
            end
            if (i_cmd.uop == U_FETCH_LO) begin
                r_pc <= r_pc + 12'd2;
            end
            if (i_cmd.uop == U_EXEC) begin
                if (skip) begin
                    r_pc <= r_pc + 12'd2;
                end
                case (grp)
                    OPG_SYS: begin
                        if (kk == KK_CLS) begin
                            r_f_valid <= '0;
                        end else if (kk == KK_RET && op_x == 4'd0) begin
                            r_sp <= sp_dec;
                            r_pc <= r_stack[sp_dec];
                        end
                    end
                    OPG_JP: r_pc <= nnn;
                    OPG_CALL: begin
                        r_stack[r_sp] <= r_pc;
                        r_sp <= sp_inc;
                        r_pc <= nnn;
                    end
                    OPG_LDIX: r_i <= {4'd0, nnn};
                    OPG_MISC: begin
                        case (kk)
                            KK_WAITK: if (r_keys == 16'd0) r_pc <= r_pc - 12'd2;
                            KK_SETDT: r_dt <= r_vx;
                            KK_ADDIX: r_i <= r_i + {8'd0, r_vx};
                            KK_FONT:  r_i <= {4'd0, C_FONT_START} +
                                             16'({1'b0, r_vx[3:0], 2'b00} +
                                                 {3'd0, r_vx[3:0]});
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_v_rd_ok <= r_v_valid[v_raddr];
        r_f_rd_ok <= (f_raddr < RW'(SCREEN_HEIGHT - 1) || f_raddr == RW'(SCREEN_HEIGHT - 1))
                     && r_f_valid[f_raddr];
        case (i_cmd.uop)
            U_ACCEPT: begin
                r_keys   <= i_in.keys_pressed;
                r_rd     <= 64'd0;
                r_wait   <= 1'b0;
                r_unimpl <= 1'b0;
                r_row_ok <= (i_in.address < 12'(SCREEN_HEIGHT));
            end
            U_MEM_CAP:  r_rd <= {56'd0, m_rdata};
            U_ROW_CAP:  r_rd <= r_row_ok ? frow : 64'd0;
            U_FETCH_HI: r_op[15:8] <= m_rdata;
            U_FETCH_LO: r_op[7:0] <= m_rdata;
            U_VX_CAP:   r_vx <= vrd;
            U_VY_CAP:   r_vy <= vrd;
            U_EXEC: begin
                r_cnt    <= 4'd0;
                r_vf_acc <= 1'b0;
                r_px     <= 6'(r_vx % 8'(C_SCREEN_WIDTH));
                r_q      <= py_prod[21:16];
                r_unimpl <= (grp == OPG_JPV0) || (grp == OPG_RND);
                r_wait   <= (grp == OPG_MISC) && (kk == KK_WAITK) && (r_keys == 16'd0);
            end
            U_DRW_MOD: r_py <= py_rem[RW-1:0];
            U_DRW_XOR: begin
                r_vf_acc <= r_vf_acc | (|(frow & spr_mask));
                r_cnt    <= r_cnt + 4'd1;
            end
            U_BCD, U_STR_WR, U_LD_WR: r_cnt <= r_cnt + 4'd1;
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out.read_data       <= r_rd;
            r_out.program_counter <= r_pc;
            r_out.waiting_for_key <= r_wait;
            r_out.unimplemented   <= r_unimpl;
        end
    end

    // Status to the sequencer
    assign o_status.in_cmd    = t_command'(i_in.command);
    assign o_status.op        = r_op;
    assign o_status.clr_last  = &r_clr_addr;
    assign o_status.cnt_eq_n  = (r_cnt == n4);
    assign o_status.cnt_eq_x  = (r_cnt == op_x);
    assign o_status.bcd_last  = (r_cnt == 4'd2);
    assign o_status.sy_out    = (sy >= SYW'(SCREEN_HEIGHT));
    assign o_status.keys_none = (r_keys == 16'd0);

    assign o_out = r_out;
endmodule

// ===== hw/rtl/chip8_interpreter_core.sv =====
// Top level of the CHIP-8 core: sequencer plus datapath.
// After reset the core loads the font and zeroes main memory, one byte per
// cycle, before it takes the first word. A write goes from accept to done, a
// memory or row read adds a capture step, and an instruction fetches two halves,
// reads Vx and Vy, executes and may write VF and Vx; a draw adds a row step, a
// read and XOR per row and a VF write, BCD a write per digit, save or load a
// read and a write per register. One command is in flight at a time; the next
// word is taken while the previous result still waits in the output register.
module chip8_interpreter_core #(
    parameter int SCREEN_HEIGHT = 32,
    parameter int STACK_DEPTH   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  c8i_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output c8i_pkg::t_out_word  o_out
);
    import c8i_pkg::*;

    t_cmd    cmd;
    t_status status;

    c8i_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(status), .o_cmd(cmd)
    );

    c8i_dp #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .i_in(i_in), .o_status(status), .o_out(o_out)
    );
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the CHIP-8 core: command stimulus, predictor and result checker.
`timescale 1ns / 100ps

module tb_top;
    import c8i_pkg::*;

    localparam int SCR_H = 32;
    localparam int STK_D = 16;
    localparam int LIMIT = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out;

    chip8_interpreter_core #(.SCREEN_HEIGHT(SCR_H), .STACK_DEPTH(STK_D)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    // Predicted machine state
    logic [7:0]  mem_m [4096];
    logic [63:0] fb_m [SCR_H];
    logic [7:0]  v_m [16];
    logic [15:0] i_m;
    logic [11:0] pc_m;
    logic [3:0]  sp_m;
    logic [11:0] stk_m [STK_D];
    logic [7:0]  dt_m;
    logic [7:0]  st_m;

    t_out_word expected_words[$];
    int        mismatches;
    int        cycles;
    int        hold_off;
    bit        long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** chip8_interpreter_core: FAILED **");
            $finish;
        end
    end

    function automatic void model_reset();
        for (int a = 0; a < 4096; a++) mem_m[a] = 8'h00;
        for (int a = 0; a < 80; a++) mem_m[C_FONT_START + a] = C_FONT[a];
        for (int r = 0; r < SCR_H; r++) fb_m[r] = '0;
        for (int r = 0; r < 16; r++) v_m[r] = '0;
        for (int r = 0; r < STK_D; r++) stk_m[r] = '0;
        i_m = '0; pc_m = C_PROGRAM_START; sp_m = '0; dt_m = '0; st_m = '0;
    endfunction

    function automatic void run_alu(logic [3:0] x, logic [3:0] y, logic [3:0] sel);
        logic [7:0] vx;
        logic [7:0] vy;
        logic [8:0] sum;
        vx = v_m[x];
        vy = v_m[y];
        case (sel)
            ALU_MOV: v_m[x] = vy;
            ALU_OR:  v_m[x] = vx | vy;
            ALU_AND: v_m[x] = vx & vy;
            ALU_XOR: v_m[x] = vx ^ vy;
            ALU_ADD: begin
                sum = vx + vy;
                v_m[REG_VF] = {7'd0, sum[8]};
                v_m[x] = sum[7:0];
            end
            ALU_SUB: begin
                v_m[REG_VF] = {7'd0, vx > vy};
                v_m[x] = vx - vy;
            end
            ALU_SHR: begin
                v_m[REG_VF] = {7'd0, vx[0]};
                v_m[x] = vx >> 1;
            end
            ALU_SUBN: begin
                v_m[REG_VF] = {7'd0, vy > vx};
                v_m[x] = vy - vx;
            end
            ALU_SHL: begin
                v_m[REG_VF] = {7'd0, vx[7]};
                v_m[x] = vx << 1;
            end
            default: ;
        endcase
    endfunction

    function automatic void draw_sprite(logic [3:0] x, logic [3:0] y, logic [3:0] n);
        int px;
        int py;
        logic [7:0] b;
        px = v_m[x] % 64;
        py = v_m[y] % SCR_H;
        v_m[REG_VF] = 8'd0;
        for (int r = 0; r < n; r++) begin
            b = mem_m[12'(i_m + r)];
            if (py + r >= SCR_H) break;
            for (int c = 0; c < 8; c++) begin
                if (b[7 - c] && px + c < 64) begin
                    if (fb_m[py + r][63 - px - c]) v_m[REG_VF] = 8'd1;
                    fb_m[py + r][63 - px - c] ^= 1'b1;
                end
            end
        end
    endfunction

    function automatic void run_instr(logic [15:0] keys, output bit waiting,
                                      output bit unimpl);
        logic [15:0] op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  kk;
        logic [7:0]  vx;
        logic        held;
        int          k;
        op = {mem_m[pc_m], mem_m[12'(pc_m + 1)]};
        x = op[11:8]; y = op[7:4]; kk = op[7:0];
        vx = v_m[x];
        waiting = 0; unimpl = 0;
        pc_m = pc_m + 12'd2;
        case (op[15:12])
            OPG_SYS: begin
                if (kk == KK_CLS) begin
                    for (int r = 0; r < SCR_H; r++) fb_m[r] = '0;
                end else if (kk == KK_RET && x == 4'h0) begin
                    sp_m = sp_m - 4'd1;
                    pc_m = stk_m[sp_m];
                end
            end
            OPG_JP:   pc_m = op[11:0];
            OPG_CALL: begin
                stk_m[sp_m] = pc_m;
                sp_m = sp_m + 4'd1;
                pc_m = op[11:0];
            end
            OPG_SEI:  if (vx == kk) pc_m += 12'd2;
            OPG_SNEI: if (vx != kk) pc_m += 12'd2;
            OPG_SER:  if (vx == v_m[y]) pc_m += 12'd2;
            OPG_LDI:  v_m[x] = kk;
            OPG_ADDI: v_m[x] = vx + kk;
            OPG_ALU:  run_alu(x, y, op[3:0]);
            OPG_SNER: if (vx != v_m[y]) pc_m += 12'd2;
            OPG_LDIX: i_m = {4'd0, op[11:0]};
            OPG_JPV0, OPG_RND: unimpl = 1;
            OPG_DRW:  draw_sprite(x, y, op[3:0]);
            OPG_KEY: begin
                held = keys[vx[3:0]];
                if ((kk == KK_SKP && held) || (kk == KK_SKNP && !held)) pc_m += 12'd2;
            end
            default: begin
                case (kk)
                    KK_LDDT: v_m[x] = dt_m;
                    KK_WAITK: begin
                        k = 16;
                        for (int b = 15; b >= 0; b--) if (keys[b]) k = b;
                        if (k < 16) v_m[x] = 8'(k);
                        else begin
                            pc_m = pc_m - 12'd2;
                            waiting = 1;
                        end
                    end
                    KK_SETDT: dt_m = vx;
                    8'h18:    st_m = vx;
                    KK_ADDIX: i_m = i_m + vx;
                    KK_FONT:  i_m = C_FONT_START + vx[3:0] * 5;
                    KK_BCD: begin
                        mem_m[12'(i_m)]     = vx / 100;
                        mem_m[12'(i_m + 1)] = vx / 10 % 10;
                        mem_m[12'(i_m + 2)] = vx % 10;
                    end
                    KK_STORE: for (int r = 0; r <= x; r++) mem_m[12'(i_m + r)] = v_m[r];
                    KK_LOAD:  for (int r = 0; r <= x; r++) v_m[r] = mem_m[12'(i_m + r)];
                    default: ;
                endcase
            end
        endcase
    endfunction

    // Predict the result word of one command and queue it
    function automatic void predict_command(t_in_word w);
        t_out_word e;
        bit wt;
        bit un;
        e = '0;
        case (t_command'(w.command))
            CMD_WRITE: mem_m[w.address] = w.write_data;
            CMD_READ:  e.read_data = {56'd0, mem_m[w.address]};
            CMD_EXEC: begin
                run_instr(w.keys_pressed, wt, un);
                e.waiting_for_key = wt;
                e.unimplemented = un;
            end
            default:   if (w.address < SCR_H) e.read_data = fb_m[w.address];
        endcase
        e.program_counter = pc_m;
        expected_words.push_back(e);
    endfunction

    // Send one word; bursts with random gaps between them
    int burst_left;
    task automatic send_word(t_in_word w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in <= w;
        i_in_valid <= 1'b1;
        predict_command(w);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_cmd(t_command c, logic [11:0] a, logic [7:0] d, logic [15:0] k);
        t_in_word w;
        w.command = c; w.address = a; w.write_data = d; w.keys_pressed = k;
        send_word(w);
    endtask

    // Place an opcode at the current PC and execute it
    task automatic exec_op(logic [15:0] op, logic [15:0] keys);
        send_cmd(CMD_WRITE, pc_m, op[15:8], 16'($urandom));
        send_cmd(CMD_WRITE, 12'(pc_m + 1), op[7:0], 16'($urandom));
        send_cmd(CMD_EXEC, 12'($urandom), 8'($urandom), keys);
    endtask

    // Drop valid and wait for every pending result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: random stall pattern plus requested long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_off <= 0;
        end else if (long_hold_req && hold_off == 0) begin
            hold_off <= 300;
            i_out_ready <= 1'b0;
        end else if (hold_off > 1) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            hold_off <= 0;
            i_out_ready <= ((cycles / 64) % 4 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", o_out);
            end else begin
                e = expected_words.pop_front();
                if (o_out.read_data !== e.read_data ||
                    o_out.program_counter !== e.program_counter ||
                    o_out.waiting_for_key !== e.waiting_for_key ||
                    o_out.unimplemented !== e.unimplemented) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp data %h pc %h wait %b unimpl %b, got %h %h %b %b",
                                 e.read_data, e.program_counter, e.waiting_for_key,
                                 e.unimplemented, o_out.read_data, o_out.program_counter,
                                 o_out.waiting_for_key, o_out.unimplemented);
                end
            end
        end
    end

    // Directed: memory ends, font readback, row reads in and out of range
    task automatic test_memory_edges();
        send_cmd(CMD_READ, C_FONT_START, 8'h00, 16'h0000);
        send_cmd(CMD_WRITE, 12'hFFF, 8'hFF, 16'hFFFF);
        send_cmd(CMD_READ, 12'hFFF, 8'h00, 16'h0000);
        send_cmd(CMD_WRITE, 12'h000, 8'h00, 16'h0000);
        send_cmd(CMD_READ, 12'h000, 8'hFF, 16'hFFFF);
        send_cmd(CMD_ROW, 12'd31, 8'h00, 16'h0000);
        send_cmd(CMD_ROW, 12'hFFF, 8'h00, 16'h0000);
    endtask

    // Directed: a selection of instruction classes and their corner cases
    task automatic test_instructions();
        exec_op(16'h60FF, 16'h0000);  // V0 = FF
        exec_op(16'h61FF, 16'h0000);
        exec_op(16'h8014, 16'h0000);  // carry
        exec_op(16'h8F15, 16'h0000);  // flag then result in VF
        exec_op(16'hF029, 16'h0000);
        exec_op(16'hD01F, 16'h0000);  // draw to the bottom edge
        exec_op(16'hD01F, 16'h0000);  // collision
        exec_op(16'hF00A, 16'h0000);  // key wait, none held
        exec_op(16'hF30A, 16'h8004);
        exec_op(16'hB123, 16'h0000);
        exec_op(16'hC0FF, 16'h0000);
        exec_op(16'h00EE, 16'h0000);  // underflow
        exec_op(16'h2FFE, 16'h0000);  // call near top of memory
        exec_op(16'hAFFE, 16'h0000);
        exec_op(16'hF133, 16'h0000);  // BCD wraps
        exec_op(16'hFF55, 16'h0000);
        exec_op(16'h00E0, 16'h0000);
    endtask

    // Random opcodes weighted toward register setup and useful work
    function automatic logic [15:0] random_opcode();
        logic [15:0] op;
        op = 16'($urandom);
        case ($urandom_range(0, 9))
            0: op[15:12] = OPG_LDI;
            1: op = {OPG_ALU, op[11:4], ($urandom_range(0, 1) != 0) ? ALU_SHL
                                                                     : 4'($urandom_range(0, 7))};
            2: op = {OPG_DRW, op[11:4], 4'($urandom_range(0, 15))};
            3: begin
                op[15:12] = OPG_MISC;
                case ($urandom_range(0, 9))
                    0: op[7:0] = KK_LDDT;  1: op[7:0] = KK_WAITK;
                    2: op[7:0] = KK_SETDT; 3: op[7:0] = 8'h18;
                    4: op[7:0] = KK_ADDIX; 5: op[7:0] = KK_FONT;
                    6: op[7:0] = KK_BCD;   7: op[7:0] = KK_STORE;
                    8: op[7:0] = KK_LOAD;  default: ;
                endcase
            end
            4: begin
                op[15:12] = OPG_KEY;
                op[7:0] = ($urandom_range(0, 1) != 0) ? KK_SKP : KK_SKNP;
            end
            5: op = {OPG_SYS, 4'h0, ($urandom_range(0, 1) != 0) ? KK_RET : KK_CLS};
            default: ;
        endcase
        return op;
    endfunction

    task automatic test_random_programs(int n);
        int sent;
        logic [15:0] keys;
        sent = 0;
        while (sent < n) begin
            keys = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
            case ($urandom_range(0, 9))
                0: send_cmd(CMD_READ, 12'($urandom), 8'($urandom), 16'($urandom));
                1: send_cmd(CMD_ROW, 12'($urandom_range(0, 40)), 8'($urandom),
                            16'($urandom));
                2: send_cmd(CMD_WRITE, 12'($urandom), 8'($urandom), 16'($urandom));
                3: send_cmd(CMD_EXEC, 12'($urandom), 8'($urandom), keys);
                default: begin
                    exec_op(random_opcode(), keys);
                    sent += 2;
                end
            endcase
            sent++;
        end
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        wait (hold_off != 0);
        long_hold_req = 1'b0;
        test_random_programs(30);
    endtask

    initial begin
        cycles = 0;
        mismatches = 0;
        burst_left = 0;
        long_hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        model_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_memory_edges();
        test_instructions();
        wait_drained();
        test_backpressure();
        test_random_programs(800);
        wait_drained();
        test_random_programs(800);
        wait_drained();
        repeat (200) @(negedge i_clk);

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("** chip8_interpreter_core: PASSED **");
        end else begin
            $display("** chip8_interpreter_core: FAILED **");
        end
        $finish;
    end

endmodule
